// ===== hdl/obot_pkg.sv =====
// Shared widths, stage layout and register indexes for the oriented box overlap test.
package obot_pkg;

  localparam int COORD_WIDTH = 16;
  localparam int AXIS_WIDTH  = 16;
  localparam int EXT_WIDTH   = 15;
  localparam int AXIS_FRAC   = 14;

  localparam int CFG_WIDTH   = (COORD_WIDTH > AXIS_WIDTH) ? COORD_WIDTH : AXIS_WIDTH;
  localparam int NUM_REGS    = 8;
  localparam int CFG_IDX_W   = $clog2(NUM_REGS);

  // center difference, exact
  localparam int DIFF_W      = COORD_WIDTH + 1;
  // axis by axis product and its absolute sum
  localparam int AA_W        = 2 * AXIS_WIDTH;
  localparam int AASUM_W     = AA_W + 1;
  localparam int PROJ_W      = 2 * AXIS_WIDTH;
  // axis by difference product and its absolute sum
  localparam int AD_W        = AXIS_WIDTH + DIFF_W;
  localparam int ADSUM_W     = AD_W + 1;
  localparam int DPROJ_W     = AXIS_WIDTH + COORD_WIDTH;
  // extent by projection product
  localparam int EP_W        = EXT_WIDTH + PROJ_W;
  // common compare scale
  localparam int LHS_W       = DPROJ_W + AXIS_FRAC;
  localparam int RHS_W       = EP_W + 2;
  localparam int CMP_W       = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  // pipeline: four work stages plus the output register
  localparam int NUM_STAGES  = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REF_CENTER_X = 3'd0,
    REG_REF_CENTER_Y = 3'd1,
    REG_REF_AXIS0_X  = 3'd2,
    REG_REF_AXIS0_Y  = 3'd3,
    REG_REF_AXIS1_X  = 3'd4,
    REG_REF_AXIS1_Y  = 3'd5,
    REG_REF_EXTENT0  = 3'd6,
    REG_REF_EXTENT1  = 3'd7
  } cfg_idx_e;

  // unit axis (1.0 in Q2.14)
  localparam logic signed [AXIS_WIDTH-1:0] AXIS_ONE = AXIS_WIDTH'(1 << AXIS_FRAC);

endpackage

// ===== hdl/oriented_box_overlap_test_2d.sv =====
// Top level: pipelined 2D separating axis test of a box stream against a reference box.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-------------------------------------
//  in       | sink      | in_valid_i / in_ready_o   | box_center_*, box_axis*_*, box_extent*
//  out      | source    | out_valid_o / out_ready_i | overlaps_o
//  cfg      | sink      | cfg_we_i (no wait)        | cfg_idx_i, cfg_wdata_i
//
// One request per cycle sustained while out_ready_i is high. Five register stages (four
// arithmetic stages plus the output register), the first loaded at the accepting edge;
// the depth is set by the multiply-then-add chain.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the reference box
// registers with a unit-axis box at the origin with zero extents.
// Each stage loads when it is empty or the stage after it moves, so a stalled output only
// backs up as far as the first bubble; nothing is dropped or repeated under backpressure.
// Reference registers feed the stages directly and must only change while idle.
module oriented_box_overlap_test_2d (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration
  input  logic                                   cfg_we_i,
  input  logic [obot_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [obot_pkg::CFG_WIDTH-1:0]         cfg_wdata_i,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [obot_pkg::COORD_WIDTH-1:0] box_center_x_i,
  input  logic signed [obot_pkg::COORD_WIDTH-1:0] box_center_y_i,
  input  logic signed [obot_pkg::AXIS_WIDTH-1:0]  box_axis0_x_i,
  input  logic signed [obot_pkg::AXIS_WIDTH-1:0]  box_axis0_y_i,
  input  logic signed [obot_pkg::AXIS_WIDTH-1:0]  box_axis1_x_i,
  input  logic signed [obot_pkg::AXIS_WIDTH-1:0]  box_axis1_y_i,
  input  logic [obot_pkg::EXT_WIDTH-1:0]          box_extent0_i,
  input  logic [obot_pkg::EXT_WIDTH-1:0]          box_extent1_i,
  // result channel
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic                                   overlaps_o
);

  import obot_pkg::*;

  // ---------------------------------------------------------------------------
  // Reference box registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_WIDTH-1:0] ref_cx_q, ref_cy_q;
  logic signed [AXIS_WIDTH-1:0]  ref_ax_q [2];
  logic signed [AXIS_WIDTH-1:0]  ref_ay_q [2];
  logic [EXT_WIDTH-1:0]          ref_e_q  [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_cx_q    <= '0;
      ref_cy_q    <= '0;
      ref_ax_q[0] <= AXIS_ONE;
      ref_ay_q[0] <= '0;
      ref_ax_q[1] <= '0;
      ref_ay_q[1] <= AXIS_ONE;
      ref_e_q[0]  <= '0;
      ref_e_q[1]  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        REG_REF_CENTER_X: ref_cx_q    <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_REF_CENTER_Y: ref_cy_q    <= cfg_wdata_i[COORD_WIDTH-1:0];
        REG_REF_AXIS0_X:  ref_ax_q[0] <= cfg_wdata_i[AXIS_WIDTH-1:0];
        REG_REF_AXIS0_Y:  ref_ay_q[0] <= cfg_wdata_i[AXIS_WIDTH-1:0];
        REG_REF_AXIS1_X:  ref_ax_q[1] <= cfg_wdata_i[AXIS_WIDTH-1:0];
        REG_REF_AXIS1_Y:  ref_ay_q[1] <= cfg_wdata_i[AXIS_WIDTH-1:0];
        REG_REF_EXTENT0:  ref_e_q[0]  <= cfg_wdata_i[EXT_WIDTH-1:0];
        REG_REF_EXTENT1:  ref_e_q[1]  <= cfg_wdata_i[EXT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: stage k loads when empty or when stage k+1 loads.
  // Stage NUM_STAGES-1 is the output register.
  // ---------------------------------------------------------------------------
  logic [NUM_STAGES-1:0] vld_q, vld_d;
  logic [NUM_STAGES-1:0] load;

  always_comb begin
    load[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready_i;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      load[k] = !vld_q[k] || load[k+1];
    end
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (k == 0) vld_d[k] = load[k] ? in_valid_i : vld_q[k];
      else        vld_d[k] = load[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_ready_o  = load[0];
  assign out_valid_o = vld_q[NUM_STAGES-1];

  // ---------------------------------------------------------------------------
  // Stage 1: center difference, axis-by-axis partial products
  // aa index 2*j+c: j = 2*ref_axis + box_axis, c = 0 for x, 1 for y
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0]     s1_dx_d, s1_dy_d, s1_dx_q, s1_dy_q;
  logic signed [AA_W-1:0]       s1_aa_d [8];
  logic signed [AA_W-1:0]       s1_aa_q [8];
  logic signed [AXIS_WIDTH-1:0] in_bax [2];
  logic signed [AXIS_WIDTH-1:0] in_bay [2];
  logic signed [AXIS_WIDTH-1:0] s1_bax_q [2];
  logic signed [AXIS_WIDTH-1:0] s1_bay_q [2];
  logic [EXT_WIDTH-1:0]         s1_be_q [2];

  assign in_bax[0] = box_axis0_x_i;
  assign in_bay[0] = box_axis0_y_i;
  assign in_bax[1] = box_axis1_x_i;
  assign in_bay[1] = box_axis1_y_i;

  always_comb begin
    s1_dx_d = DIFF_W'(box_center_x_i) - DIFF_W'(ref_cx_q);
    s1_dy_d = DIFF_W'(box_center_y_i) - DIFF_W'(ref_cy_q);
    for (int p = 0; p < 2; p++) begin
      for (int q = 0; q < 2; q++) begin
        s1_aa_d[2*(2*p+q)]   = AA_W'(ref_ax_q[p]) * AA_W'(in_bax[q]);
        s1_aa_d[2*(2*p+q)+1] = AA_W'(ref_ay_q[p]) * AA_W'(in_bay[q]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      s1_dx_q     <= s1_dx_d;
      s1_dy_q     <= s1_dy_d;
      s1_aa_q     <= s1_aa_d;
      s1_bax_q    <= in_bax;
      s1_bay_q    <= in_bay;
      s1_be_q[0]  <= box_extent0_i;
      s1_be_q[1]  <= box_extent1_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: axis-by-difference products (lanes: ref0, ref1, box0, box1),
  // absolute axis dot products p00, p01, p10, p11
  // ---------------------------------------------------------------------------
  logic signed [AXIS_WIDTH-1:0] lane_ax [4];
  logic signed [AXIS_WIDTH-1:0] lane_ay [4];
  logic signed [AD_W-1:0]       s2_adx_d [4];
  logic signed [AD_W-1:0]       s2_ady_d [4];
  logic signed [AD_W-1:0]       s2_adx_q [4];
  logic signed [AD_W-1:0]       s2_ady_q [4];
  logic [PROJ_W-1:0]            s2_p_d [4];
  logic [PROJ_W-1:0]            s2_p_q [4];
  logic [EXT_WIDTH-1:0]         s2_be_q [2];

  always_comb begin
    logic signed [AASUM_W-1:0] sum;
    lane_ax[0] = ref_ax_q[0];
    lane_ay[0] = ref_ay_q[0];
    lane_ax[1] = ref_ax_q[1];
    lane_ay[1] = ref_ay_q[1];
    lane_ax[2] = s1_bax_q[0];
    lane_ay[2] = s1_bay_q[0];
    lane_ax[3] = s1_bax_q[1];
    lane_ay[3] = s1_bay_q[1];
    for (int k = 0; k < 4; k++) begin
      s2_adx_d[k] = AD_W'(lane_ax[k]) * AD_W'(s1_dx_q);
      s2_ady_d[k] = AD_W'(lane_ay[k]) * AD_W'(s1_dy_q);
    end
    for (int j = 0; j < 4; j++) begin
      sum = AASUM_W'(s1_aa_q[2*j]) + AASUM_W'(s1_aa_q[2*j+1]);
      s2_p_d[j] = sum[AASUM_W-1] ? PROJ_W'(-sum) : PROJ_W'(sum);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      s2_adx_q <= s2_adx_d;
      s2_ady_q <= s2_ady_d;
      s2_p_q   <= s2_p_d;
      s2_be_q  <= s1_be_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: absolute center projection per lane, extent-by-projection products.
  // Lanes on reference axes pair box extents with p; lanes on box axes pair
  // reference extents with p.
  // ---------------------------------------------------------------------------
  logic [DPROJ_W-1:0]   s3_dp_d [4];
  logic [DPROJ_W-1:0]   s3_dp_q [4];
  logic [EP_W-1:0]      s3_ep0_d [4];
  logic [EP_W-1:0]      s3_ep1_d [4];
  logic [EP_W-1:0]      s3_ep0_q [4];
  logic [EP_W-1:0]      s3_ep1_q [4];
  logic [EXT_WIDTH-1:0] s3_e_d [4];
  logic [EXT_WIDTH-1:0] s3_e_q [4];

  always_comb begin
    logic signed [ADSUM_W-1:0] sum;
    for (int k = 0; k < 4; k++) begin
      sum = ADSUM_W'(s2_adx_q[k]) + ADSUM_W'(s2_ady_q[k]);
      s3_dp_d[k] = sum[ADSUM_W-1] ? DPROJ_W'(-sum) : DPROJ_W'(sum);
    end
    for (int k = 0; k < 2; k++) begin
      // reference axis k: p(k,box0), p(k,box1)
      s3_ep0_d[k] = EP_W'(s2_be_q[0]) * EP_W'(s2_p_q[2*k]);
      s3_ep1_d[k] = EP_W'(s2_be_q[1]) * EP_W'(s2_p_q[2*k+1]);
      s3_e_d[k]   = ref_e_q[k];
      // box axis k: p(ref0,k), p(ref1,k)
      s3_ep0_d[k+2] = EP_W'(ref_e_q[0]) * EP_W'(s2_p_q[k]);
      s3_ep1_d[k+2] = EP_W'(ref_e_q[1]) * EP_W'(s2_p_q[k+2]);
      s3_e_d[k+2]   = s2_be_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      s3_dp_q  <= s3_dp_d;
      s3_ep0_q <= s3_ep0_d;
      s3_ep1_q <= s3_ep1_d;
      s3_e_q   <= s3_e_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: both sides on the Q.28 scale
  // ---------------------------------------------------------------------------
  logic [CMP_W-1:0] s4_lhs_d [4];
  logic [CMP_W-1:0] s4_rhs_d [4];
  logic [CMP_W-1:0] s4_lhs_q [4];
  logic [CMP_W-1:0] s4_rhs_q [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      s4_lhs_d[k] = CMP_W'(s3_dp_q[k]) << AXIS_FRAC;
      s4_rhs_d[k] = (CMP_W'(s3_e_q[k]) << (2 * AXIS_FRAC))
                  + CMP_W'(s3_ep0_q[k]) + CMP_W'(s3_ep1_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[3]) begin
      s4_lhs_q <= s4_lhs_d;
      s4_rhs_q <= s4_rhs_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register: overlap unless some axis separates (touching overlaps)
  // ---------------------------------------------------------------------------
  logic overlaps_d, overlaps_q;

  always_comb begin
    overlaps_d = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (s4_lhs_q[k] > s4_rhs_q[k]) overlaps_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[4]) begin
      overlaps_q <= overlaps_d;
    end
  end

  assign overlaps_o = overlaps_q;

endmodule

// ===== hdl/obot_checker.sv =====
// Port-level checker for the oriented box overlap test, bound to the top level.
module obot_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic overlaps_o
);

  import obot_pkg::*;

  // held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(overlaps_o))
    else $error("result changed while stalled");

  // an empty output register never backpressures the request side
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("request stalled with empty output");

  // a draining output lets the whole pipe move
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("request stalled while output drains");

  // fixed latency without backpressure
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) ##1 out_ready_i ##1 out_ready_i ##1 out_ready_i
      ##1 out_ready_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

endmodule

bind oriented_box_overlap_test_2d obot_checker u_obot_checker (.*);
